// ----- sv/tcpu_pkg.sv -----
// Shared constants, codes, control/status structs and address helper for the tiny CPU core.
`timescale 1ns / 1ps

package tcpu_pkg;

   localparam int IMEM_BYTES = 256;
   localparam int DMEM_BYTES = 256;
   localparam int NUM_REGS   = 16;

   localparam int IMEM_AW = $clog2(IMEM_BYTES);
   localparam int DMEM_AW = $clog2(DMEM_BYTES);
   localparam int REG_AW  = $clog2(NUM_REGS);

   // floor(2^16 / size), used to reduce an 8-bit address modulo a memory size
   localparam logic [12:0] IMEM_RECIP = 13'(65536 / IMEM_BYTES);
   localparam logic [12:0] DMEM_RECIP = 13'(65536 / DMEM_BYTES);
   localparam logic [8:0]  IMEM_SIZE9 = 9'(IMEM_BYTES);
   localparam logic [8:0]  DMEM_SIZE9 = 9'(DMEM_BYTES);

   localparam int REQ_W = 24;  // cmd(3) + addr(8) + value(8), padded to bytes
   localparam int RSP_W = 24;  // pc(8) + halted(1) + read_value(8), padded

   typedef enum logic [2:0] {
      CMD_LOAD_INSTR = 3'd0,
      CMD_LOAD_DATA  = 3'd1,
      CMD_LOAD_REG   = 3'd2,
      CMD_STEP       = 3'd3,
      CMD_READ_DATA  = 3'd4,
      CMD_READ_REG   = 3'd5
   } cmd_code_type;

   typedef enum logic [3:0] {
      OP_ADD  = 4'd0,
      OP_SUB  = 4'd1,
      OP_MUL  = 4'd2,
      OP_INC  = 4'd3,
      OP_AND  = 4'd4,
      OP_OR   = 4'd5,
      OP_XOR  = 4'd6,
      OP_NOT  = 4'd7,
      OP_SLLI = 4'd8,
      OP_SRLI = 4'd9,
      OP_LI   = 4'd10,
      OP_LD   = 4'd11,
      OP_ST   = 4'd12,
      OP_JMP  = 4'd13,
      OP_BEQZ = 4'd14,
      OP_HLT  = 4'd15
   } opcode_type;

   // controller -> datapath
   typedef struct packed {
      logic ready;      // idle, input word may be taken
      logic do_cmd;     // perform the host command held in the word register
      logic fetch_hi;   // read instruction byte at pc
      logic fetch_lo;   // capture high byte, read byte at pc+1
      logic decode;     // capture low byte
      logic read_bc;    // read source registers B and C
      logic read_a;     // hold B, read register A
      logic execute;    // ALU, branch, store, load address
      logic load_wb;    // write loaded byte into register A
      logic respond;    // result word goes to the output register
   } ctrl_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic is_step;
      logic halted;
      logic is_load;
      logic rsp_free;
   } ctrl_stat_type;

   // a mod n for 8-bit a and 16 <= n <= 256, via reciprocal and one correction
   function automatic logic [7:0] addr_mod(input logic [7:0] a, input logic [8:0] n,
                                           input logic [12:0] recip);
      logic [20:0] prod;
      logic [4:0]  quo;
      logic [13:0] back;
      logic [8:0]  rem;
      prod = 21'(a) * 21'(recip);
      quo  = prod[20:16];
      back = 14'(quo) * 14'(n);
      rem  = {1'b0, a} - back[8:0];
      if (rem >= n) begin
         rem = rem - n;
      end
      return rem[7:0];
   endfunction

endpackage

// ----- sv/tcpu_ctrl.sv -----
// Sequencing state machine of the tiny CPU core.
`timescale 1ns / 1ps

module tcpu_ctrl import tcpu_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   input  ctrl_stat_type stat,
   output ctrl_cmd_type  cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD,
      ST_FETCH_HI,
      ST_FETCH_LO,
      ST_DECODE,
      ST_READ_BC,
      ST_READ_A,
      ST_EXEC,
      ST_LOAD_WB,
      ST_RESP
   } state_type;

   state_type    state_ff, state_in;
   ctrl_cmd_type cmd_ff, cmd_in;

   function automatic ctrl_cmd_type cmd_for(input state_type s);
      ctrl_cmd_type c;
      c = '0;
      case (s)
         ST_IDLE:     c.ready    = 1'b1;
         ST_CMD:      c.do_cmd   = 1'b1;
         ST_FETCH_HI: c.fetch_hi = 1'b1;
         ST_FETCH_LO: c.fetch_lo = 1'b1;
         ST_DECODE:   c.decode   = 1'b1;
         ST_READ_BC:  c.read_bc  = 1'b1;
         ST_READ_A:   c.read_a   = 1'b1;
         ST_EXEC:     c.execute  = 1'b1;
         ST_LOAD_WB:  c.load_wb  = 1'b1;
         ST_RESP:     c.respond  = 1'b1;
         default:     c = '0;
      endcase
      return c;
   endfunction

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:     if (req_tvalid) state_in = ST_CMD;
         ST_CMD:      state_in = (stat.is_step && !stat.halted) ? ST_FETCH_HI : ST_RESP;
         ST_FETCH_HI: state_in = ST_FETCH_LO;
         ST_FETCH_LO: state_in = ST_DECODE;
         ST_DECODE:   state_in = ST_READ_BC;
         ST_READ_BC:  state_in = ST_READ_A;
         ST_READ_A:   state_in = ST_EXEC;
         ST_EXEC:     state_in = stat.is_load ? ST_LOAD_WB : ST_RESP;
         ST_LOAD_WB:  state_in = ST_RESP;
         ST_RESP:     if (stat.rsp_free) state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
      cmd_in = cmd_for(state_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cmd_ff   <= cmd_for(ST_IDLE);
      end else begin
         state_ff <= state_in;
         cmd_ff   <= cmd_in;
      end
   end

   assign cmd = cmd_ff;

endmodule

// ----- sv/tcpu_dpath.sv -----
// Datapath of the tiny CPU core: memories, register file, ALU, PC and result register.
`timescale 1ns / 1ps

module tcpu_dpath import tcpu_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               word_take,
   input  logic [REQ_W-1:0]   req_tdata,
   input  logic               rsp_tready,
   input  ctrl_cmd_type       cmd,
   output ctrl_stat_type      stat,
   output logic               rsp_tvalid,
   output logic [RSP_W-1:0]   rsp_tdata
);

   logic [7:0] instr_mem [IMEM_BYTES];
   logic [7:0] data_mem  [DMEM_BYTES];
   logic [7:0] reg_file  [NUM_REGS];

   // held host word
   logic [2:0] wcmd_ff;
   logic [7:0] waddr_ff, wvalue_ff;

   logic [7:0] pc_ff, pc_in;
   logic       halt_ff, halt_in;
   logic [7:0] ir_hi_ff, ir_lo_ff;
   logic [7:0] imem_q_ff, dmem_q_ff;
   logic [7:0] rf_p0_q_ff, rf_p1_q_ff;
   logic [7:0] opb_ff;
   logic       rsp_valid_ff;
   logic [7:0] rsp_pc_ff, rsp_rd_ff;
   logic       rsp_halt_ff;

   opcode_type op;
   logic [3:0] fa, fb, fc;
   logic [7:0] ra, rb, rc;
   logic [7:0] res;
   logic       res_wr;
   logic [7:0] daddr8;
   logic [7:0] pc_plus2;
   logic       rsp_load;
   logic [7:0] read_value;

   logic [7:0] imem_a8, imem_mod, dmem_a8, dmem_mod, host_imod;
   logic       imem_we, imem_re, dmem_we, dmem_re, rf_we, rf_re0, rf_re1;
   logic [7:0] dmem_wd, rf_wd;
   logic [REG_AW-1:0] rf_wa, rf_ra0, rf_ra1;

   assign op = opcode_type'(ir_hi_ff[7:4]);
   assign fa = ir_hi_ff[3:0];
   assign fb = ir_lo_ff[7:4];
   assign fc = ir_lo_ff[3:0];
   assign ra = rf_p0_q_ff;
   assign rb = opb_ff;
   assign rc = rf_p1_q_ff;
   assign daddr8   = rb + {{4{fc[3]}}, fc};
   assign pc_plus2 = pc_ff + 8'd2;

   // ALU
   always_comb begin
      logic [15:0] prod;
      prod   = 16'(rb) * 16'(rc);
      res    = '0;
      res_wr = 1'b1;
      case (op)
         OP_ADD:  res = rb + rc;
         OP_SUB:  res = rb - rc;
         OP_MUL:  res = prod[7:0];
         OP_INC:  res = ra + 8'd1;
         OP_AND:  res = rb & rc;
         OP_OR:   res = rb | rc;
         OP_XOR:  res = rb ^ rc;
         OP_NOT:  res = ~rb;
         OP_SLLI: res = rb << fc;
         OP_SRLI: res = rb >> fc;
         OP_LI:   res = {fb, fc};
         default: res_wr = 1'b0;  // LD writes back later; ST, JMP, BEQZ, HLT none
      endcase
   end

   // PC and halt
   always_comb begin
      pc_in   = pc_ff;
      halt_in = halt_ff;
      if (cmd.execute) begin
         pc_in = pc_plus2;
         case (op)
            OP_JMP:  pc_in = pc_plus2 + {fa[2:0], fb, 1'b0};
            OP_BEQZ: if (ra == 8'd0) pc_in = pc_plus2 + {fb[2:0], fc, 1'b0};
            OP_HLT:  halt_in = 1'b1;
            default: pc_in = pc_plus2;
         endcase
      end
   end

   // memory port controls
   always_comb begin
      imem_a8   = cmd.fetch_hi ? pc_ff : pc_ff + 8'd1;
      imem_mod  = addr_mod(imem_a8, IMEM_SIZE9, IMEM_RECIP);
      host_imod = addr_mod(waddr_ff, IMEM_SIZE9, IMEM_RECIP);
      imem_we   = cmd.do_cmd && (wcmd_ff == CMD_LOAD_INSTR);
      imem_re   = cmd.fetch_hi || cmd.fetch_lo;

      dmem_a8  = cmd.execute ? daddr8 : waddr_ff;
      dmem_mod = addr_mod(dmem_a8, DMEM_SIZE9, DMEM_RECIP);
      dmem_we  = (cmd.do_cmd && (wcmd_ff == CMD_LOAD_DATA)) ||
                 (cmd.execute && (op == OP_ST));
      dmem_re  = (cmd.do_cmd && (wcmd_ff == CMD_READ_DATA)) ||
                 (cmd.execute && (op == OP_LD));
      dmem_wd  = cmd.execute ? ra : wvalue_ff;

      rf_we = (cmd.do_cmd && (wcmd_ff == CMD_LOAD_REG)) ||
              (cmd.execute && res_wr) || cmd.load_wb;
      rf_wa = cmd.do_cmd ? waddr_ff[REG_AW-1:0] : fa;
      rf_wd = cmd.do_cmd ? wvalue_ff : (cmd.load_wb ? dmem_q_ff : res);

      rf_re0 = (cmd.do_cmd && (wcmd_ff == CMD_READ_REG)) || cmd.read_bc || cmd.read_a;
      rf_ra0 = cmd.do_cmd ? waddr_ff[REG_AW-1:0] : (cmd.read_bc ? fb : fa);
      rf_re1 = cmd.read_bc;
      rf_ra1 = fc;
   end

   always_ff @(posedge clock) begin
      if (imem_we) begin
         instr_mem[host_imod[IMEM_AW-1:0]] <= wvalue_ff;
      end
      if (imem_re) begin
         imem_q_ff <= instr_mem[imem_mod[IMEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (dmem_we) begin
         data_mem[dmem_mod[DMEM_AW-1:0]] <= dmem_wd;
      end
      if (dmem_re) begin
         dmem_q_ff <= data_mem[dmem_mod[DMEM_AW-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (rf_we) begin
         reg_file[rf_wa] <= rf_wd;
      end
      if (rf_re0) begin
         rf_p0_q_ff <= reg_file[rf_ra0];
      end
      if (rf_re1) begin
         rf_p1_q_ff <= reg_file[rf_ra1];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (word_take) begin
         wcmd_ff   <= req_tdata[2:0];
         waddr_ff  <= req_tdata[10:3];
         wvalue_ff <= req_tdata[18:11];
      end
      if (cmd.fetch_lo) ir_hi_ff <= imem_q_ff;
      if (cmd.decode)   ir_lo_ff <= imem_q_ff;
      if (cmd.read_a)   opb_ff   <= rf_p0_q_ff;
      if (rsp_load) begin
         rsp_pc_ff   <= pc_ff;
         rsp_halt_ff <= halt_ff;
         rsp_rd_ff   <= read_value;
      end
   end

   always_comb begin
      case (wcmd_ff)
         CMD_READ_DATA: read_value = dmem_q_ff;
         CMD_READ_REG:  read_value = rf_p0_q_ff;
         default:       read_value = 8'd0;
      endcase
   end

   assign rsp_load = cmd.respond && stat.rsp_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff        <= '0;
         halt_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pc_ff   <= pc_in;
         halt_ff <= halt_in;
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign stat.is_step  = (wcmd_ff == CMD_STEP);
   assign stat.halted   = halt_ff;
   assign stat.is_load  = (op == OP_LD);
   assign stat.rsp_free = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_rd_ff, rsp_halt_ff, rsp_pc_ff};

endmodule

// ----- sv/tiny_8bit_cpu_core.sv -----
// Top level of the tiny 8-bit CPU core: controller plus datapath behind stream ports.
`timescale 1ns / 1ps

// Usage:
//  One word in on req_*, one word out on rsp_* for every word taken.
//  A request carries a command: load an instruction byte, a data byte or a
//  register, read a data byte or a register back, or step one instruction.
//  The response carries the PC and halt flag after the command and the byte
//  read (zero for commands that read nothing).
//  A load, a read, an unused code or a step while halted goes from the
//  command state straight to the response state; a step that executes a
//  load from data memory also passes through the load write-back state.
//  The core takes one word at a time; a step walks the state machine
//  through two fetches on the single instruction memory port, two register
//  file reads on its two read ports, execute and the optional load write-back.
//  Reset clears PC, halt flag and all handshakes; memories and registers hold
//  garbage until written.
//  If the receiver stalls, the result sits in the output register and the
//  core accepts the next word; it only waits if a second result is ready
//  before the first has been taken.

module tiny_8bit_cpu_core import tcpu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [REQ_W-1:0] req_tdata,   // cmd[2:0], addr[10:3], value[18:11], zero pad
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output logic [RSP_W-1:0] rsp_tdata    // pc[7:0], halted[8], read_value[16:9], zero pad
);

   ctrl_cmd_type  ctrl_cmd;
   ctrl_stat_type ctrl_stat;
   logic          word_take;

   assign req_tready = ctrl_cmd.ready;
   assign word_take  = req_tvalid && ctrl_cmd.ready;

   tcpu_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .stat       (ctrl_stat),
      .cmd        (ctrl_cmd)
   );

   tcpu_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .word_take  (word_take),
      .req_tdata  (req_tdata),
      .rsp_tready (rsp_tready),
      .cmd        (ctrl_cmd),
      .stat       (ctrl_stat),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

   // a taken word keeps the core busy for at least the next cycle
   a_busy_after_take: assert property (@(posedge clock) disable iff (reset)
      word_take |=> !req_tready)
      else $error("core ready right after taking a word");

   // halt is sticky until reset
   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      ctrl_stat.halted |=> ctrl_stat.halted)
      else $error("halt flag dropped");

   // PC starts at zero and only moves by even amounts
   a_pc_even: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !rsp_tdata[0])
      else $error("odd program counter reported");

   // exactly one datapath phase is active at a time
   a_one_phase: assert property (@(posedge clock) disable iff (reset)
      $onehot(ctrl_cmd))
      else $error("controller drives more or less than one phase");

endmodule
